// ===== rtl/pkglide_pkg.sv =====
// Shared types and codes for the portamento key glide block.
// No dependencies; imported by every module of the block.
`default_nettype none

package pkglide_pkg;

    localparam int KEY_W  = 16;   // key value width
    localparam int LEN_W  = 20;   // glide length / position width
    localparam int OFF_W  = 17;   // signed key offset width
    localparam int CNT_W  = 4;    // iteration counter, counts KEY_W steps
    localparam int ALU_W  = 21;   // shared add/sub operand width

    // Item kind carried on tuser
    typedef enum logic [1:0] {
        FUNC_SET_KEY = 2'd0,
        FUNC_KEY_ON  = 2'd1,
        FUNC_TICK    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Request from the glide control to the scale unit
    typedef struct packed {
        logic              start;
        logic              neg;    // offset is negative: round quotient up
        logic [KEY_W-1:0]  mag;    // |offset|
        logic [LEN_W-1:0]  mult;   // glide position after increment
        logic [LEN_W-1:0]  den;    // glide length, nonzero
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [KEY_W-1:0]  quot;   // rounded |offset| * pos / len
    } md_rsp_t;

endpackage : pkglide_pkg

`default_nettype wire

// ===== rtl/pkglide_alu.sv =====
// Shared adder/subtractor used by the scale unit for both the
// multiply and divide passes. Depends on pkglide_pkg.
`default_nettype none

module pkglide_alu (
    input  wire pkglide_pkg::alu_op_t          op,
    input  wire logic [pkglide_pkg::ALU_W-1:0] a,
    input  wire logic [pkglide_pkg::ALU_W-1:0] b,
    output logic      [pkglide_pkg::ALU_W:0]   res   // top bit: carry / borrow
);
    import pkglide_pkg::*;

    always_comb
    begin
        unique case (op)
            ALU_ADD: res = {1'b0, a} + {1'b0, b};
            ALU_SUB: res = {1'b0, a} - {1'b0, b};
            default: res = {1'b0, a};
        endcase
    end

endmodule : pkglide_alu

`default_nettype wire

// ===== rtl/pkglide_muldiv.sv =====
// Iterative scale unit: shift-add multiply then restoring divide, both
// on one shared pkglide_alu. Depends on pkglide_pkg and pkglide_alu.
`default_nettype none

module pkglide_muldiv (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pkglide_pkg::md_req_t req,
    output pkglide_pkg::md_rsp_t      rsp
);
    import pkglide_pkg::*;

    typedef enum logic [3:0] {
        MD_IDLE = 4'b0001,
        MD_MUL  = 4'b0010,
        MD_DIV  = 4'b0100,
        MD_DONE = 4'b1000
    } md_state_t;

    md_state_t        state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    // {hi, lo} is the 36-bit product during MUL; hi = remainder, lo = quotient in DIV
    logic [LEN_W-1:0] hi_reg, hi_next;
    logic [KEY_W-1:0] lo_reg, lo_next;
    logic [LEN_W-1:0] mult_reg, mult_next;
    logic [LEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;

    alu_op_t          alu_op;
    logic [ALU_W-1:0] alu_a, alu_b;
    logic [ALU_W:0]   alu_res;
    logic [ALU_W-1:0] mul_sum;
    logic [ALU_W-1:0] div_trial;

    pkglide_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign div_trial = {hi_reg, lo_reg[KEY_W-1]};

    always_comb
    begin
        if (state_reg == MD_DIV)
        begin
            alu_op = ALU_SUB;
            alu_a  = div_trial;
            alu_b  = {1'b0, den_reg};
        end
        else
        begin
            alu_op = ALU_ADD;
            alu_a  = {1'b0, hi_reg};
            alu_b  = {1'b0, mult_reg};
        end
    end

    assign mul_sum = lo_reg[0] ? alu_res[ALU_W-1:0] : {1'b0, hi_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mult_next  = mult_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    hi_next    = '0;
                    lo_next    = req.mag;
                    mult_next  = req.mult;
                    den_next   = req.den;
                    neg_next   = req.neg;
                    cnt_next   = '0;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                hi_next  = mul_sum[ALU_W-1:1];
                lo_next  = {mul_sum[0], lo_reg[KEY_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KEY_W - 1))
                begin
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                // borrow clear: trial remainder >= divisor
                if (!alu_res[ALU_W])
                begin
                    hi_next = alu_res[LEN_W-1:0];
                end
                else
                begin
                    hi_next = div_trial[LEN_W-1:0];
                end
                lo_next  = {lo_reg[KEY_W-2:0], ~alu_res[ALU_W]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KEY_W - 1))
                begin
                    state_next = MD_DONE;
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        mult_reg <= mult_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    // negative offset rounds toward minus infinity: ceil of the magnitude
    assign rsp.done = (state_reg == MD_DONE);
    assign rsp.quot = lo_reg + KEY_W'(neg_reg && (hi_reg != '0));

endmodule : pkglide_muldiv

`default_nettype wire

// ===== rtl/portamento_key_glide_unit.sv =====
// Top level of the portamento key glide block: stream ports, key state,
// glide control. Depends on pkglide_pkg and pkglide_muldiv.
`default_nettype none

// Linear portamento for one synth voice. Each input beat carries a kind on
// tuser (set target key, key on, sample tick) and a key on tdata; each beat
// yields exactly one output beat with the key after the beat is applied.
// Set-key, key-on, idle ticks and settling ticks finish in the accept cycle
// and their result is registered for the next cycle. A tick that moves a
// running glide computes origin + floor(offset * position / length) on the
// iterative scale unit: 16 shift-add multiply steps and 16 restoring divide
// steps on one shared 21-bit adder, then a done state; the result goes to
// the output register, and the next input beat can be taken once the block
// is idle again. One beat is in flight at a time; s_axis_tready
// is low while the scale unit runs or while an unread result would block the
// output register. glide_length is written on the cfg channel (always
// ready) and must only be changed while the block is idle. There is no
// clearing pass after reset.
module portamento_key_glide_unit #(
    parameter int unsigned DEFAULT_KEY = 24576
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [pkglide_pkg::KEY_W-1:0] s_axis_tdata,  // [15:0] new_key
    input  wire logic [1:0]                   s_axis_tuser,  // [1:0] func
    // output stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [pkglide_pkg::KEY_W-1:0] m_axis_tdata,  // [15:0] current_key
    // glide_length register
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [pkglide_pkg::LEN_W-1:0] cfg_data
);
    import pkglide_pkg::*;

    localparam logic [KEY_W-1:0] RESET_KEY = KEY_W'(DEFAULT_KEY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [LEN_W-1:0]        glide_length_reg, glide_length_next;
    logic [KEY_W-1:0]        key_current_reg, key_current_next;
    logic [KEY_W-1:0]        key_origin_reg, key_origin_next;
    logic signed [OFF_W-1:0] key_offset_reg, key_offset_next;
    logic [LEN_W-1:0]        glide_position_reg, glide_position_next;
    logic                    out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]        out_data_reg, out_data_next;

    func_t                   func;
    logic                    in_beat;
    logic [KEY_W-1:0]        target_key;
    logic [OFF_W-1:0]        offset_neg;
    logic [KEY_W-1:0]        offset_mag;
    logic [KEY_W-1:0]        scaled_key;
    md_req_t                 md_req;
    md_rsp_t                 md_rsp;

    assign func          = func_t'(s_axis_tuser);
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // target = origin + offset, always within key range
    assign target_key = key_origin_reg + key_offset_reg[KEY_W-1:0];
    assign offset_neg = -key_offset_reg;
    assign offset_mag = key_offset_reg[OFF_W-1] ? offset_neg[KEY_W-1:0]
                                                : key_offset_reg[KEY_W-1:0];
    assign scaled_key = key_offset_reg[OFF_W-1] ? key_origin_reg - md_rsp.quot
                                                : key_origin_reg + md_rsp.quot;

    pkglide_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_comb
    begin
        state_next          = state_reg;
        glide_length_next   = glide_length_reg;
        key_current_next    = key_current_reg;
        key_origin_next     = key_origin_reg;
        key_offset_next     = key_offset_reg;
        glide_position_next = glide_position_reg;
        out_valid_next      = out_valid_reg && !m_axis_tready;
        out_data_next       = out_data_reg;

        md_req.start = 1'b0;
        md_req.neg   = key_offset_reg[OFF_W-1];
        md_req.mag   = offset_mag;
        md_req.mult  = glide_position_reg + 1'b1;
        md_req.den   = glide_length_reg;

        if (cfg_valid && cfg_ready)
        begin
            glide_length_next = cfg_data;
        end

        if (in_beat)
        begin
            out_valid_next = 1'b1;
            out_data_next  = key_current_reg;
            unique case (func)
                FUNC_SET_KEY:
                begin
                    key_origin_next     = key_current_reg;
                    key_offset_next     = $signed({1'b0, s_axis_tdata})
                                        - $signed({1'b0, key_current_reg});
                    glide_position_next = '0;
                end
                FUNC_KEY_ON:
                begin
                    key_current_next = target_key;
                    key_origin_next  = target_key;
                    key_offset_next  = '0;
                    out_data_next    = target_key;
                end
                FUNC_TICK:
                begin
                    if ((glide_length_reg != '0) && (key_offset_reg != '0))
                    begin
                        if (glide_position_reg < glide_length_reg)
                        begin
                            // glide step: result comes from the scale unit
                            glide_position_next = glide_position_reg + 1'b1;
                            md_req.start        = 1'b1;
                            out_valid_next      = 1'b0;
                            state_next          = ST_CALC;
                        end
                        else
                        begin
                            // settle on target
                            key_current_next = target_key;
                            key_origin_next  = target_key;
                            key_offset_next  = '0;
                            out_data_next    = target_key;
                        end
                    end
                    else
                    begin
                        key_current_next = target_key;
                        out_data_next    = target_key;
                    end
                end
                default:
                begin
                    out_data_next = key_current_reg;
                end
            endcase
        end

        // output register is empty here: accept required it free
        if ((state_reg == ST_CALC) && md_rsp.done)
        begin
            key_current_next = scaled_key;
            out_data_next    = scaled_key;
            out_valid_next   = 1'b1;
            state_next       = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            glide_length_reg   <= '0;
            key_current_reg    <= RESET_KEY;
            key_origin_reg     <= RESET_KEY;
            key_offset_reg     <= '0;
            glide_position_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            glide_length_reg   <= glide_length_next;
            key_current_reg    <= key_current_next;
            key_origin_reg     <= key_origin_next;
            key_offset_reg     <= key_offset_next;
            glide_position_reg <= glide_position_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule : portamento_key_glide_unit

`default_nettype wire

// ===== rtl/pkglide_chk.sv =====
// Port-level checker for portamento_key_glide_unit, bound to the top level.
// Depends on pkglide_pkg.
`default_nettype none

module pkglide_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [1:0]                    s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [pkglide_pkg::KEY_W-1:0] m_axis_tdata
);
    import pkglide_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // a blocked output register stops intake
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while result is blocked");

    // anything but a tick answers in the next cycle
    a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != FUNC_TICK) |=> m_axis_tvalid)
        else $error("single-cycle beat produced no result");

endmodule : pkglide_chk

bind portamento_key_glide_unit pkglide_chk u_pkglide_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
